@@ hw/rtl/greedy_box_suppression_defines.svh @@
// Assertion macros shared by the greedy box suppression RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gbs_pkg.sv @@
// Shared types, constants and helper functions for greedy box suppression.
// Used by the kept-list memory, the overlap unit and the top level.
`default_nettype none

package gbs_pkg;

  localparam int MAX_KEPT   = 64;
  localparam int COORD_BITS = 16;
  localparam int CLASS_W    = 8;
  localparam int THR_W      = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SLOT_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int AREA_W = 2 * COORD_BITS;
  localparam int UNI_W  = AREA_W + 1;
  localparam int PROD_W = THR_W + UNI_W;

  localparam logic [THR_W-1:0] IOU_THR_RESET = THR_W'(22938);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_AGNOSTIC = CFG_IDX_W'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        span_t;
  typedef logic [AREA_W-1:0]            area_t;
  typedef logic [CLASS_W-1:0]           class_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  typedef struct packed {
    box_t   box;
    class_t cls;
    area_t  area;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic suppress;
  } iou_res_t;

  // Length of the interval from lo to hi, zero when hi is not above lo.
  function automatic span_t span(input coord_t lo, input coord_t hi);
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS + 1)'(hi) - (COORD_BITS + 1)'(lo);
    return (d > 0) ? d[COORD_BITS-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gbs_kept_mem.sv @@
// Kept-list storage: corners, class and area of each stored survivor.
// One write port and one registered read port; depends on gbs_pkg.
`default_nettype none

module gbs_kept_mem (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [gbs_pkg::ADDR_W-1:0] waddr_i,
  input  gbs_pkg::entry_t           wdata_i,
  input  wire                       re_i,
  input  wire [gbs_pkg::ADDR_W-1:0] raddr_i,
  output gbs_pkg::entry_t           rdata_o
);
  import gbs_pkg::*;

  entry_t mem [MAX_KEPT];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/gbs_iou_unit.sv @@
// Pipelined overlap test: intersection, union, and the scaled IoU compare.
// Takes one kept entry per cycle, five register stages; depends on gbs_pkg.
`default_nettype none

module gbs_iou_unit (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      req_valid_i,
  input  gbs_pkg::box_t            box_i,
  input  gbs_pkg::area_t           area_i,
  input  gbs_pkg::class_t          cls_i,
  input  gbs_pkg::entry_t          entry_i,
  input  wire                      agnostic_i,
  input  wire [gbs_pkg::THR_W-1:0] thr_i,
  output logic                     busy_o,
  output gbs_pkg::iou_res_t        res_o
);
  import gbs_pkg::*;

  coord_t il, it, ir, ib;

  logic  va_q, vb_q, vc_q, vd_q, ve_q;
  logic  ma_q, mb_q, mc_q, md_q;
  span_t wa_q, ha_q;
  area_t ka_q, kb_q;
  area_t ib_q, ic_q;
  logic [UNI_W-1:0]  uc_q;
  logic [PROD_W-1:0] lhs_q, rhs_q;
  logic              sup_q;

  always_comb begin
    il = (box_i.l > entry_i.box.l) ? box_i.l : entry_i.box.l;
    it = (box_i.t > entry_i.box.t) ? box_i.t : entry_i.box.t;
    ir = (box_i.r < entry_i.box.r) ? box_i.r : entry_i.box.r;
    ib = (box_i.b < entry_i.box.b) ? box_i.b : entry_i.box.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      va_q <= req_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // Stage A: clamped intersection extents and class filter.
    wa_q <= span(il, ir);
    ha_q <= span(it, ib);
    ka_q <= entry_i.area;
    ma_q <= agnostic_i || (entry_i.cls == cls_i);
    // Stage B: intersection area.
    ib_q <= area_t'(wa_q) * area_t'(ha_q);
    kb_q <= ka_q;
    mb_q <= ma_q;
    // Stage C: union; it never goes negative since the overlap fits both boxes.
    uc_q <= UNI_W'(area_i) + UNI_W'(kb_q) - UNI_W'(ib_q);
    ic_q <= ib_q;
    mc_q <= mb_q;
    // Stage D: both sides of the scaled compare.
    rhs_q <= PROD_W'(thr_i) * PROD_W'(uc_q);
    lhs_q <= PROD_W'({ic_q, {FRAC_BITS{1'b0}}});
    md_q  <= mc_q;
    // Stage E: a zero union gives zero on both sides and so never suppresses.
    sup_q <= md_q && (lhs_q > rhs_q);
  end

  assign busy_o         = va_q || vb_q || vc_q || vd_q || ve_q;
  assign res_o.valid    = ve_q;
  assign res_o.suppress = sup_q;

endmodule

`default_nettype wire

@@ hw/rtl/greedy_box_suppression.sv @@
// Top level of greedy box suppression: sequencer, config and result register.
// Instantiates gbs_kept_mem and gbs_iou_unit; depends on gbs_pkg and the defines.
//
//   beat        direction  handshake                  payload
//   in          to block   in_valid_i / in_stall_o    first_box, corners, class_label
//   out         from block out_valid_o / out_stall_i  keep, slot, list_full
//   cfg         to block   cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// An input beat first works out the box area in S_SPAN and S_AREA. S_SCAN then reads the
// kept entries one at a time into the shared overlap pipeline, all N that remain after any
// first_box clear, and ends with a step that reads none; S_DRAIN waits for the pipeline to
// empty, and S_FIN finishes. An empty list reads no entry in S_SCAN.
// Reset empties the kept list and loads the register defaults; the memory is not cleared.
// in_stall_o is high while a box is in work; a stalled result holds the finish step.
`default_nettype none
`include "greedy_box_suppression_defines.svh"

module greedy_box_suppression (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [gbs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [gbs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire                            first_box_i,
  input  wire signed [gbs_pkg::COORD_BITS-1:0] left_i,
  input  wire signed [gbs_pkg::COORD_BITS-1:0] top_i,
  input  wire signed [gbs_pkg::COORD_BITS-1:0] right_i,
  input  wire signed [gbs_pkg::COORD_BITS-1:0] bottom_i,
  input  wire [gbs_pkg::CLASS_W-1:0]     class_label_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           keep_o,
  output logic [gbs_pkg::SLOT_W-1:0]     slot_o,
  output logic                           list_full_o
);
  import gbs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SPAN  = 6'b000010,
    S_AREA  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [THR_W-1:0] thr_q;
  logic             agn_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             keep_q, keep_d;
  logic             rd_valid_q, rd_valid_d;
  box_t             box_q;
  class_t           cls_q;
  span_t            w_q, h_q;
  area_t            area_q;

  logic             out_valid_q;
  logic             keep_out_q, full_out_q;
  logic [SLOT_W-1:0] slot_out_q;

  logic     in_fire, fin_fire, has_room, rd_en, mem_we;
  entry_t   rd_entry, wr_entry;
  iou_res_t res;
  logic     unit_busy;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign fin_fire = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign has_room = count_q < CNT_W'(MAX_KEPT);
  assign rd_en    = (state_q == S_SCAN) && (k_q < count_q);
  assign mem_we   = fin_fire && keep_q && has_room;

  assign wr_entry.box  = box_q;
  assign wr_entry.cls  = cls_q;
  assign wr_entry.area = area_q;

  gbs_kept_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (k_q[ADDR_W-1:0]),
    .rdata_o (rd_entry)
  );

  gbs_iou_unit u_iou (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (rd_valid_q),
    .box_i       (box_q),
    .area_i      (area_q),
    .cls_i       (cls_q),
    .entry_i     (rd_entry),
    .agnostic_i  (agn_q),
    .thr_i       (thr_q),
    .busy_o      (unit_busy),
    .res_o       (res)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    k_d        = k_q;
    keep_d     = keep_q;
    rd_valid_d = rd_en;
    if (res.valid && res.suppress) begin
      keep_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SPAN;
          keep_d  = 1'b1;
          k_d     = '0;
          if (first_box_i) begin
            count_d = '0;
          end
        end
      end
      S_SPAN:  state_d = S_AREA;
      S_AREA:  state_d = S_SCAN;
      S_SCAN: begin
        if (rd_en) begin
          k_d = k_q + CNT_W'(1);
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last test result has been folded in once the pipeline is empty.
        if (!rd_valid_q && !unit_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_fire) begin
          state_d = S_IDLE;
          if (mem_we) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      keep_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= IOU_THR_RESET;
      agn_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      keep_q      <= keep_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= (out_valid_q && out_stall_i) || fin_fire;
      if (cfg_we_i) begin
        priority if (cfg_index_i == CFG_IOU_THRESHOLD) begin
          thr_q <= cfg_wdata_i[THR_W-1:0];
        end else if (cfg_index_i == CFG_CLASS_AGNOSTIC) begin
          agn_q <= cfg_wdata_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      box_q.l <= left_i;
      box_q.t <= top_i;
      box_q.r <= right_i;
      box_q.b <= bottom_i;
      cls_q   <= class_label_i;
    end
    if (state_q == S_SPAN) begin
      w_q <= span(box_q.l, box_q.r);
      h_q <= span(box_q.t, box_q.b);
    end
    if (state_q == S_AREA) begin
      area_q <= area_t'(w_q) * area_t'(h_q);
    end
    if (fin_fire) begin
      keep_out_q <= keep_q;
      full_out_q <= keep_q && !has_room;
      slot_out_q <= mem_we ? SLOT_W'(count_q) : '0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign keep_o      = keep_out_q;
  assign slot_o      = slot_out_q;
  assign list_full_o = full_out_q;

  `GBS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_KEPT), "kept count above capacity")
  `GBS_ASSERT_NOW(a_full_needs_keep, out_valid_o && list_full_o, keep_o && (slot_o == '0),
                  "list_full reported without a kept box")
  `GBS_ASSERT_NOW(a_slot_needs_keep, out_valid_o && (slot_o != '0), keep_o && !list_full_o,
                  "slot given to a box that was not stored")
  `GBS_ASSERT_NEXT(a_fin_result, fin_fire, out_valid_o && (state_q == S_IDLE),
                   "finish step did not present a result")
  `GBS_ASSERT_NOW(a_no_test_idle, state_q == S_IDLE, !unit_busy && !rd_valid_q,
                  "overlap test in flight while idle")

endmodule

`default_nettype wire

@@ sim/greedy_box_suppression_test.sv @@
// Self-checking testbench for greedy_box_suppression: directed boxes, then random frames
// under several threshold, class and idling settings, each result checked in order.
// Depends on gbs_pkg and the greedy_box_suppression RTL.
`timescale 1ns / 1ps

module greedy_box_suppression_test;
  import gbs_pkg::*;

  localparam int LATENCY          = MAX_KEPT + 16;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int RANDOM_SEG_ITEMS = 175;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  typedef longint unsigned u64_t;

  typedef struct {
    logic   first;
    box_t   box;
    class_t cls;
  } cand_t;

  typedef struct {
    logic              keep;
    logic [SLOT_W-1:0] slot;
    logic              full;
  } verdict_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic                  first_box_i   = 1'b0;
  coord_t                left_i        = '0;
  coord_t                top_i         = '0;
  coord_t                right_i       = '0;
  coord_t                bottom_i      = '0;
  class_t                class_label_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  keep_o;
  logic [SLOT_W-1:0]     slot_o;
  logic                  list_full_o;

  // Predictor state: the kept list and the two registers.
  box_t             kept_box  [MAX_KEPT];
  class_t           kept_cls  [MAX_KEPT];
  u64_t             kept_area [MAX_KEPT];
  int               kept_cnt     = 0;
  logic [THR_W-1:0] thr_reg      = IOU_THR_RESET;
  logic             agnostic_reg = 1'b0;

  verdict_t    verdict_q[$];
  verdict_t    due;
  int          err_cnt     = 0;
  int          boxes_sent  = 0;
  int          idle_cycles = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;

  greedy_box_suppression u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .first_box_i   (first_box_i),
    .left_i        (left_i),
    .top_i         (top_i),
    .right_i       (right_i),
    .bottom_i      (bottom_i),
    .class_label_i (class_label_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .keep_o        (keep_o),
    .slot_o        (slot_o),
    .list_full_o   (list_full_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic u64_t extent(coord_t lo, coord_t hi);
    longint d;
    d = longint'(hi) - longint'(lo);
    return (d > 0) ? d : 0;
  endfunction

  // Works out the verdict for one box and updates the kept list.
  function automatic verdict_t judge_box(cand_t c);
    verdict_t v;
    u64_t     area_a;
    u64_t     inter;
    u64_t     uni;
    bit       hit;
    if (c.first) kept_cnt = 0;
    area_a = extent(c.box.l, c.box.r) * extent(c.box.t, c.box.b);
    hit = 1'b0;
    for (int k = 0; k < kept_cnt; k++) begin
      if (!agnostic_reg && kept_cls[k] != c.cls) continue;
      inter = extent(c.box.l > kept_box[k].l ? c.box.l : kept_box[k].l,
                     c.box.r < kept_box[k].r ? c.box.r : kept_box[k].r) *
              extent(c.box.t > kept_box[k].t ? c.box.t : kept_box[k].t,
                     c.box.b < kept_box[k].b ? c.box.b : kept_box[k].b);
      uni = area_a + kept_area[k] - inter;
      // A zero union never suppresses.
      if (uni != 0 && inter * 65536 > u64_t'(thr_reg) * uni) hit = 1'b1;
    end
    v.keep = !hit;
    v.slot = '0;
    v.full = 1'b0;
    if (!hit) begin
      if (kept_cnt < MAX_KEPT) begin
        kept_box[kept_cnt]  = c.box;
        kept_cls[kept_cnt]  = c.cls;
        kept_area[kept_cnt] = area_a;
        v.slot = SLOT_W'(kept_cnt);
        kept_cnt++;
      end else begin
        v.full = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
    err_cnt++;
    $display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
  endfunction

  function automatic cand_t mk(int first, int l, int t, int r, int b, int cls);
    cand_t c;
    c.first = (first != 0);
    c.box.l = coord_t'(l);
    c.box.t = coord_t'(t);
    c.box.r = coord_t'(r);
    c.box.b = coord_t'(b);
    c.cls   = class_t'(cls);
    return c;
  endfunction

  function automatic coord_t clip(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  // Sends one box beat and records its verdict once it is accepted.
  task automatic send_box(cand_t c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    first_box_i   <= c.first;
    left_i        <= c.box.l;
    top_i         <= c.box.t;
    right_i       <= c.box.r;
    bottom_i      <= c.box.b;
    class_label_i <= c.cls;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    verdict_q.insert(verdict_q.size(), judge_box(c));
    boxes_sent++;
  endtask

  // Holds the sender off until every pending verdict has come back.
  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IOU_THRESHOLD:  thr_reg = data[THR_W-1:0];
      CFG_CLASS_AGNOSTIC: agnostic_reg = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic test_defaults();
    send_box(mk(1, 0, 0, 160, 160, 3));
    send_box(mk(0, 16, 16, 176, 176, 3));
    send_box(mk(0, 16, 16, 176, 176, 4));
    send_box(mk(0, 320, 320, 480, 480, 3));
    // IoU of one third, just under the default limit.
    send_box(mk(0, 80, 0, 240, 160, 3));
  endtask

  task automatic test_corner_boxes();
    send_box(mk(1, -32768, -32768, 32767, 32767, 0));
    send_box(mk(0, -32768, -32768, 32767, 32767, 0));
    // Inverted and zero-width boxes have no area, so they always survive.
    send_box(mk(0, 100, 100, -100, -100, 0));
    send_box(mk(0, 100, 100, -100, -100, 0));
    send_box(mk(0, 5, -200, 5, 200, 0));
    send_box(mk(0, 32767, 32767, -32768, -32768, 255));
    send_box(mk(0, -32768, 0, 32767, 1, 255));
  endtask

  task automatic test_thresholds();
    drain(LATENCY);
    write_reg(CFG_IOU_THRESHOLD, '0);
    send_box(mk(1, 0, 0, 100, 100, 1));
    send_box(mk(0, 99, 99, 200, 200, 1));
    send_box(mk(0, 100, 0, 200, 100, 1));
    drain(LATENCY);
    write_reg(CFG_IOU_THRESHOLD, '1);
    send_box(mk(1, 0, 0, 100, 100, 1));
    send_box(mk(0, 0, 0, 100, 100, 1));
    send_box(mk(0, 0, 0, 100, 99, 1));
    drain(LATENCY);
    write_reg(CFG_IOU_THRESHOLD, CFG_DATA_W'(IOU_THR_RESET));
    write_reg(CFG_CLASS_AGNOSTIC, {(CFG_DATA_W-1)'($urandom()), 1'b1});
    send_box(mk(1, 0, 0, 160, 160, 7));
    send_box(mk(0, 16, 16, 176, 176, 9));
  endtask

  // Writes to undecoded indexes must leave threshold and class mode alone.
  task automatic test_spare_registers();
    drain(LATENCY);
    write_reg(CFG_SPARE_A, '0);
    write_reg(CFG_SPARE_B, 16'hFFFE);
    send_box(mk(1, 0, 0, 160, 160, 7));
    send_box(mk(0, 16, 16, 176, 176, 9));
    send_box(mk(0, 80, 0, 240, 160, 9));
  endtask

  task automatic send_frame();
    int    len;
    int    nctr;
    int    ncls;
    int    base_cls;
    int    w;
    int    h;
    int    x0;
    int    y0;
    int    sel;
    int    cx [4];
    int    cy [4];
    bit    tiled;
    bit    flip;
    bit    fresh;
    cand_t c;
    tiled    = ($urandom_range(99) < 8);
    len      = tiled ? $urandom_range(80, 66) : $urandom_range(24, 1);
    nctr     = $urandom_range(4, 1);
    ncls     = $urandom_range(3, 1);
    base_cls = ($urandom_range(3) == 0) ? $urandom_range(255) : 0;
    fresh    = ($urandom_range(9) != 0);
    for (int i = 0; i < 4; i++) begin
      cx[i] = int'($urandom_range(60000)) - 30000;
      cy[i] = int'($urandom_range(60000)) - 30000;
    end
    if ($urandom_range(99) < 3) drain(0);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < 8) begin
        c.first = tiled ? 1'b0 : 1'($urandom_range(1));
        c.box   = box_t'({$urandom(), $urandom()});
        c.cls   = class_t'($urandom_range(255));
      end else begin
        if (tiled && $urandom_range(9) != 0) begin
          // Disjoint tiles all survive, so long frames run the list full.
          w  = $urandom_range(500, 100);
          h  = $urandom_range(500, 100);
          x0 = (k % 10) * 600 - 3000 + cx[0] / 2;
          y0 = (k / 10) * 600 - 3000 + cy[0] / 2;
        end else begin
          sel = $urandom_range(nctr - 1);
          w   = $urandom_range(600, 16);
          h   = $urandom_range(600, 16);
          x0  = cx[sel] + int'($urandom_range(w / 2)) - w / 4;
          y0  = cy[sel] + int'($urandom_range(h / 2)) - h / 4;
        end
        flip = ($urandom_range(19) == 0);
        c.box.l = flip ? clip(x0 + w) : clip(x0);
        c.box.r = flip ? clip(x0) : clip(x0 + w);
        c.box.t = flip ? clip(y0 + h) : clip(y0);
        c.box.b = flip ? clip(y0) : clip(y0 + h);
        c.first = (k == 0) && fresh;
        c.cls   = class_t'(base_cls + int'($urandom_range(ncls - 1)));
      end
      send_box(c);
    end
  endtask

  task automatic test_random_frames();
    int               goal;
    logic [THR_W-1:0] thr;
    for (int seg = 0; seg < 8; seg++) begin
      drain(LATENCY);
      case (seg)
        0:       thr = IOU_THR_RESET;
        1:       thr = '0;
        3:       thr = THR_W'($urandom());
        6:       thr = '1;
        default: thr = THR_W'($urandom_range(52000, 6000));
      endcase
      write_reg(CFG_IOU_THRESHOLD, CFG_DATA_W'(thr));
      write_reg(CFG_CLASS_AGNOSTIC, {(CFG_DATA_W-1)'($urandom()), 1'(seg >= 4)});
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      goal = boxes_sent + RANDOM_SEG_ITEMS;
      while (boxes_sent < goal) send_frame();
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Each accepted result beat is checked against the oldest verdict.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        $display("%0t ns: result with no box pending: keep=%0b slot=%0d list_full=%0b",
                 $time, keep_o, slot_o, list_full_o);
      end else begin
        due = verdict_q.pop_front();
        if (keep_o !== due.keep) note_mismatch("keep", 8'(due.keep), 8'(keep_o));
        if (slot_o !== due.slot) note_mismatch("slot", 8'(due.slot), 8'(slot_o));
        if (list_full_o !== due.full)
          note_mismatch("list_full", 8'(due.full), 8'(list_full_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("[greedy_box_suppression] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_corner_boxes();
    test_thresholds();
    test_spare_registers();
    test_random_frames();
    drain(LATENCY);
    if (err_cnt == 0) begin
      $display("[greedy_box_suppression] OK");
    end else begin
      $display("[greedy_box_suppression] ERROR");
    end
    $finish;
  end

endmodule
